[sv/gtu_pkg.sv]
// shared types, codes and register numbers for the graphics tag unpacker
`default_nettype none

package gtu_pkg;

    // transfer modes carried by a tag
    localparam logic [1:0] MODE_PACKED  = 2'd0;
    localparam logic [1:0] MODE_REGLIST = 2'd1;

    // register descriptors
    localparam logic [3:0] DESC_PRIM    = 4'h0;
    localparam logic [3:0] DESC_RGBAQ   = 4'h1;
    localparam logic [3:0] DESC_ST      = 4'h2;
    localparam logic [3:0] DESC_UV      = 4'h3;
    localparam logic [3:0] DESC_XYZF2   = 4'h4;
    localparam logic [3:0] DESC_XYZ2    = 4'h5;
    localparam logic [3:0] DESC_TEX0_1  = 4'h6;
    localparam logic [3:0] DESC_TEX0_2  = 4'h7;
    localparam logic [3:0] DESC_CLAMP_1 = 4'h8;
    localparam logic [3:0] DESC_XYZ3    = 4'hD;
    localparam logic [3:0] DESC_AD      = 4'hE;
    localparam logic [3:0] DESC_NOP     = 4'hF;

    // graphics register numbers
    localparam logic [7:0] REG_PRIM  = 8'h00;
    localparam logic [7:0] REG_RGBAQ = 8'h01;
    localparam logic [7:0] REG_ST    = 8'h02;
    localparam logic [7:0] REG_UV    = 8'h03;
    localparam logic [7:0] REG_XYZF2 = 8'h04;
    localparam logic [7:0] REG_XYZ2  = 8'h05;
    localparam logic [7:0] REG_XYZF3 = 8'h0C;
    localparam logic [7:0] REG_XYZ3  = 8'h0D;

    // result kinds
    localparam logic KIND_REG   = 1'b0;
    localparam logic KIND_IMAGE = 1'b1;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic        kind;
        logic [7:0]  addr;
        logic [63:0] data_low;
        logic [63:0] data_high;
        logic        last;
    } result_t;

    // results caused by one input word, already compacted to the front
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

endpackage

`default_nettype wire

[sv/gtu_unpack.sv]
// tag state registers and single-pass decode of one quadword into results
`default_nettype none

module gtu_unpack (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 fire,
    input  wire logic [63:0]          qword_low,
    input  wire logic [63:0]          qword_high,
    output gtu_pkg::result_pair_t     results
);

    logic [14:0] loops_reg, loops_next;
    logic [1:0]  mode_reg, mode_next;
    logic [4:0]  rcount_reg, rcount_next;
    logic [63:0] desc_list_reg, desc_list_next;
    logic [4:0]  desc_idx_reg, desc_idx_next;
    logic [31:0] saved_q_reg, saved_q_next;

    function automatic logic [3:0] pick_desc(input logic [63:0] list,
                                             input logic [4:0] rc,
                                             input logic [4:0] di);
        logic [4:0] diff;
        logic [3:0] pos;
        diff = rc - di;
        pos  = diff[3:0];
        return list[{pos, 2'b00} +: 4];
    endfunction

    always_comb begin
        gtu_pkg::result_t ra, rb;
        logic             va, vb;
        logic [3:0]       d;
        logic [4:0]       di_dec;
        logic [31:0]      v0, v1, v2, v3;
        logic [4:0]       rc_tag;

        loops_next     = loops_reg;
        mode_next      = mode_reg;
        rcount_next    = rcount_reg;
        desc_list_next = desc_list_reg;
        desc_idx_next  = desc_idx_reg;
        saved_q_next   = saved_q_reg;
        ra = '0;
        rb = '0;
        va = 1'b0;
        vb = 1'b0;
        d  = '0;
        di_dec = '0;
        rc_tag = '0;
        v0 = qword_low[31:0];
        v1 = qword_low[63:32];
        v2 = qword_high[31:0];
        v3 = qword_high[63:32];

        if (loops_reg == '0) begin
            // tag word
            loops_next     = qword_low[14:0];
            mode_next      = qword_low[59:58];
            desc_list_next = qword_high;
            rc_tag         = (qword_low[63:60] == 4'd0) ? 5'd16 : {1'b0, qword_low[63:60]};
            rcount_next    = rc_tag;
            desc_idx_next  = rc_tag;
            if (qword_low[59:58] != gtu_pkg::MODE_REGLIST && qword_low[46]) begin
                va = 1'b1;
                ra.kind = gtu_pkg::KIND_REG;
                ra.addr = gtu_pkg::REG_PRIM;
                ra.data_low = {54'd0, qword_low[56:47]};
            end
        end else if (mode_reg == gtu_pkg::MODE_PACKED) begin
            d = pick_desc(desc_list_reg, rcount_reg, desc_idx_reg);
            di_dec = desc_idx_reg - 5'd1;
            desc_idx_next = di_dec;
            if (di_dec == '0) begin
                loops_next    = loops_reg - 15'd1;
                desc_idx_next = rcount_reg;
            end
            ra.kind = gtu_pkg::KIND_REG;
            ra.data_low = qword_low;
            va = 1'b1;
            case (d)
                gtu_pkg::DESC_PRIM: begin
                    ra.addr = gtu_pkg::REG_PRIM;
                    ra.data_low = {32'd0, v0};
                end
                gtu_pkg::DESC_RGBAQ: begin
                    ra.addr = gtu_pkg::REG_RGBAQ;
                    ra.data_low = {saved_q_reg, v3[7:0], v2[7:0], v1[7:0], v0[7:0]};
                end
                gtu_pkg::DESC_ST: begin
                    ra.addr = gtu_pkg::REG_ST;
                    saved_q_next = v2;
                end
                gtu_pkg::DESC_UV: begin
                    ra.addr = gtu_pkg::REG_UV;
                    ra.data_low = {33'd0, v1[14:0], 1'b0, v0[14:0]};
                end
                gtu_pkg::DESC_XYZF2: begin
                    ra.addr = v3[15] ? gtu_pkg::REG_XYZF3 : gtu_pkg::REG_XYZF2;
                    ra.data_low = {v3[11:4], v2[27:4], v1[15:0], v0[15:0]};
                end
                gtu_pkg::DESC_XYZ2: begin
                    ra.addr = v3[15] ? gtu_pkg::REG_XYZ3 : gtu_pkg::REG_XYZ2;
                    ra.data_low = {v2, v1[15:0], v0[15:0]};
                end
                gtu_pkg::DESC_TEX0_1, gtu_pkg::DESC_TEX0_2, gtu_pkg::DESC_CLAMP_1: begin
                    ra.addr = {4'd0, d};
                end
                gtu_pkg::DESC_XYZ3: begin
                    ra.addr = gtu_pkg::REG_XYZ3;
                end
                gtu_pkg::DESC_AD: begin
                    ra.addr = qword_high[7:0];
                end
                default: begin
                    va = 1'b0;
                end
            endcase
        end else if (mode_reg == gtu_pkg::MODE_REGLIST) begin
            // low half
            d = pick_desc(desc_list_reg, rcount_reg, desc_idx_reg);
            di_dec = desc_idx_reg - 5'd1;
            desc_idx_next = di_dec;
            if (di_dec == '0) begin
                loops_next    = loops_reg - 15'd1;
                desc_idx_next = rcount_reg;
            end
            va = (d != gtu_pkg::DESC_NOP);
            ra.kind = gtu_pkg::KIND_REG;
            ra.addr = {4'd0, d};
            ra.data_low = qword_low;
            // high half, padding once the loops run out
            if (loops_next != '0) begin
                d = pick_desc(desc_list_reg, rcount_reg, desc_idx_next);
                di_dec = desc_idx_next - 5'd1;
                desc_idx_next = di_dec;
                if (di_dec == '0) begin
                    loops_next    = loops_next - 15'd1;
                    desc_idx_next = rcount_reg;
                end
                vb = (d != gtu_pkg::DESC_NOP);
                rb.kind = gtu_pkg::KIND_REG;
                rb.addr = {4'd0, d};
                rb.data_low = qword_high;
            end
        end else begin
            // image word passes through
            va = 1'b1;
            ra.kind = gtu_pkg::KIND_IMAGE;
            ra.addr = '0;
            ra.data_low = qword_low;
            ra.data_high = qword_high;
            loops_next = loops_reg - 15'd1;
        end

        // compact to the front and mark the last one
        results.count  = {1'b0, va} + {1'b0, vb};
        results.first  = va ? ra : rb;
        results.second = rb;
        results.first.last  = !(va && vb);
        results.second.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loops_reg     <= '0;
            mode_reg      <= gtu_pkg::MODE_PACKED;
            rcount_reg    <= '0;
            desc_list_reg <= '0;
            desc_idx_reg  <= '0;
            saved_q_reg   <= '0;
        end else if (fire) begin
            loops_reg     <= loops_next;
            mode_reg      <= mode_next;
            rcount_reg    <= rcount_next;
            desc_list_reg <= desc_list_next;
            desc_idx_reg  <= desc_idx_next;
            saved_q_reg   <= saved_q_next;
        end
    end

endmodule

`default_nettype wire

[sv/gtu_out_queue.sv]
// two-entry result queue that takes up to two results and hands out one per cycle while pop is asserted
`default_nettype none

module gtu_out_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire gtu_pkg::result_pair_t push_data,
    input  wire logic                 pop,
    output gtu_pkg::result_t          head,
    output logic                      head_valid,
    output logic [1:0]                fill
);

    gtu_pkg::result_t slot0_reg, slot0_next;
    gtu_pkg::result_t slot1_reg, slot1_next;
    logic [1:0]       count_reg, count_next;

    always_comb begin
        logic [1:0] kept;
        logic [1:0] added;
        gtu_pkg::result_t front;

        kept  = count_reg - {1'b0, pop};
        added = push ? push_data.count : 2'd0;
        front = pop ? slot1_reg : slot0_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        case (kept)
            2'd0: begin
                slot0_next = push_data.first;
                slot1_next = push_data.second;
            end
            2'd1: begin
                slot0_next = front;
                slot1_next = push_data.first;
            end
            default: begin
                slot0_next = slot0_reg;
                slot1_next = slot1_reg;
            end
        endcase
        count_next = kept + added;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign head       = slot0_reg;
    assign head_valid = (count_reg != '0);
    assign fill       = count_reg;

endmodule

`default_nettype wire

[sv/graphics_tag_unpacker_core.sv]
// top level of the graphics tag unpacker: input register, decode and result queue
// path: an accepted word waits in the input register and its results reach m_tdata from the queue head
// throughput: one input word per cycle while each word yields at most one result and m_tready stays high
// a reglist word with two writes waits until the queue is empty (queue room uses pre-pop fill)
// reset: aresetn low at a clock edge clears the tag state, the input stage and the queue
// after reset the first accepted word is decoded as a tag
`default_nettype none

module graphics_tag_unpacker_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // input quadword stream
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [127:0]  s_tdata,   // qword_low [63:0], qword_high [127:64]
    // result stream
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [135:0]       m_tdata,   // register_address [7:0], data_low [71:8],
                                          // data_high [135:72]
    output logic [0:0]         m_tuser,   // result_kind [0]
    output logic               m_tlast    // last_result
);

    // input register, parts the upstream handshake from the decode
    logic          in_valid_reg;
    logic [63:0]   in_low_reg;
    logic [63:0]   in_high_reg;

    gtu_pkg::result_pair_t results;
    gtu_pkg::result_t      head;
    logic                  head_valid;
    logic [1:0]            fill;
    logic                  fire;
    logic                  pop;
    logic [2:0]            needed;

    // a held word is decoded once the queue has room for all of its results;
    // the check uses the fill before this cycle's pop so m_tready never reaches s_tready
    assign needed = {1'b0, fill} + {1'b0, results.count};
    assign fire   = in_valid_reg && (needed <= 3'(gtu_pkg::QUEUE_DEPTH));
    assign s_tready = !in_valid_reg || fire;
    assign pop    = head_valid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_low_reg  <= s_tdata[63:0];
            in_high_reg <= s_tdata[127:64];
        end
    end

    // tag state and per-word repacking
    gtu_unpack u_unpack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .qword_low  (in_low_reg),
        .qword_high (in_high_reg),
        .results    (results)
    );

    // results wait here until the downstream side takes them
    gtu_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (fire),
        .push_data  (results),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .fill       (fill)
    );

    // output word
    assign m_tvalid = head_valid;
    assign m_tdata  = {head.data_high, head.data_low, head.addr};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

endmodule

`default_nettype wire

[sv/gtu_checker.sv]
// port-level checks for the graphics tag unpacker and their binding
`default_nettype none

module gtu_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          m_tvalid,
    input wire logic          m_tready,
    input wire logic [135:0]  m_tdata,
    input wire logic [0:0]    m_tuser,
    input wire logic          m_tlast
);

    // a stalled result word stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // image words are always the only result of their input
    a_image_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && m_tdata[7:0] == 8'd0)
        else $error("image word without last or with nonzero address");

    // register writes carry nothing in the high half
    a_reg_high_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[135:72] == 64'd0)
        else $error("register write with nonzero high half");

    // a non-last result is always followed by its partner before anything else
    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && !m_tuser[0])
        else $error("second write of a pair missing");

endmodule

bind graphics_tag_unpacker_core gtu_checker u_gtu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

[sim/graphics_tag_unpacker_core_tb.sv]
// self-checking testbench for the graphics tag unpacker: directed words, random tag sequences
`default_nettype none

module graphics_tag_unpacker_core_tb;

    // image modes have no names in the package
    localparam logic [1:0] MODE_IMAGE     = 2'd2;
    localparam logic [1:0] MODE_IMAGE_ALT = 2'd3;

    localparam int RANDOM_WORDS  = 500;
    localparam int HOLD_AT       = 120;
    localparam int PAUSE_AT      = 300;
    localparam int HOLD_CYCLES   = 200;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 20;
    localparam int TAIL_WORDS    = 8;
    localparam int CYCLE_LIMIT   = 1000000;

    // tag decoder state as the unpacker keeps it
    typedef struct {
        logic [14:0] loops;
        logic [1:0]  mode;
        logic [4:0]  nregs;
        logic [63:0] descs;
        logic [4:0]  left;
        logic [31:0] q;
    } tag_state_t;

    // one input word, optionally with a result written out by hand
    typedef struct {
        logic [63:0]      lo;
        logic [63:0]      hi;
        bit               fixed;
        int               n_fixed;
        gtu_pkg::result_t want;
    } tag_row_t;

    logic           aclk;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [127:0]   s_tdata  = '0;   // qword_low [63:0], qword_high [127:64]
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [135:0]   m_tdata;         // register_address [7:0], data_low [71:8], data_high [135:72]
    logic [0:0]     m_tuser;         // result_kind [0]
    logic           m_tlast;

    tag_state_t       tag_state;
    gtu_pkg::result_t word_out [2];
    gtu_pkg::result_t due_writes [$];
    tag_row_t         tag_plan [$];
    gtu_pkg::result_t seen;
    gtu_pkg::result_t want;
    int             mismatches  = 0;
    int             cycle_count = 0;
    bit             hold_req    = 1'b0;
    bit             light_idle  = 1'b0;
    int             burst_left  = 0;
    int             tx_quiet    = 0;

    graphics_tag_unpacker_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    function automatic void note_mismatch(string what, logic [63:0] exp_val, logic [63:0] act_val);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %h, got %h", what, exp_val, act_val);
    endfunction

    // ---------------------------------------------------------------- unpacking

    function automatic gtu_pkg::result_t reg_write(logic [7:0] addr, logic [63:0] data);
        return '{kind: gtu_pkg::KIND_REG, addr: addr, data_low: data, data_high: 64'd0,
                 last: 1'b0};
    endfunction

    // descriptor for the current position within the loop
    function automatic logic [3:0] next_desc();
        logic [3:0] pos;
        pos = 4'(tag_state.nregs - tag_state.left);
        return tag_state.descs[{pos, 2'b00} +: 4];
    endfunction

    function automatic void step_desc();
        tag_state.left = tag_state.left - 5'd1;
        if (tag_state.left == 5'd0) begin
            tag_state.loops = tag_state.loops - 15'd1;
            tag_state.left  = tag_state.nregs;
        end
    endfunction

    // decode one word, leave its results in word_out, return how many
    function automatic int unpack_word(logic [63:0] lo, logic [63:0] hi);
        int          n;
        logic [3:0]  d;
        logic [31:0] v0, v1, v2, v3;
        n = 0;
        word_out[0] = '0;
        word_out[1] = '0;
        {v1, v0} = lo;
        {v3, v2} = hi;
        if (tag_state.loops == 15'd0) begin
            tag_state.loops = lo[14:0];
            tag_state.mode  = lo[59:58];
            tag_state.nregs = (lo[63:60] == 4'd0) ? 5'd16 : {1'b0, lo[63:60]};
            tag_state.descs = hi;
            tag_state.left  = tag_state.nregs;
            if (tag_state.mode != gtu_pkg::MODE_REGLIST && lo[46]) begin
                word_out[0] = reg_write(gtu_pkg::REG_PRIM, {54'd0, lo[56:47]});
                n = 1;
            end
        end else if (tag_state.mode == gtu_pkg::MODE_PACKED) begin
            d = next_desc();
            step_desc();
            n = 1;
            case (d)
                gtu_pkg::DESC_PRIM:
                    word_out[0] = reg_write(gtu_pkg::REG_PRIM, {32'd0, v0});
                gtu_pkg::DESC_RGBAQ:
                    word_out[0] = reg_write(gtu_pkg::REG_RGBAQ,
                                    {tag_state.q, v3[7:0], v2[7:0], v1[7:0], v0[7:0]});
                gtu_pkg::DESC_ST: begin
                    tag_state.q = v2;
                    word_out[0] = reg_write(gtu_pkg::REG_ST, lo);
                end
                gtu_pkg::DESC_UV:
                    word_out[0] = reg_write(gtu_pkg::REG_UV,
                                    {33'd0, v1[14:0], 1'b0, v0[14:0]});
                gtu_pkg::DESC_XYZF2:
                    word_out[0] = reg_write(hi[47] ? gtu_pkg::REG_XYZF3 : gtu_pkg::REG_XYZF2,
                                    {v3[11:4], v2[27:4], v1[15:0], v0[15:0]});
                gtu_pkg::DESC_XYZ2:
                    word_out[0] = reg_write(hi[47] ? gtu_pkg::REG_XYZ3 : gtu_pkg::REG_XYZ2,
                                    {v2, v1[15:0], v0[15:0]});
                gtu_pkg::DESC_TEX0_1, gtu_pkg::DESC_TEX0_2, gtu_pkg::DESC_CLAMP_1:
                    word_out[0] = reg_write({4'd0, d}, lo);
                gtu_pkg::DESC_XYZ3:
                    word_out[0] = reg_write(gtu_pkg::REG_XYZ3, lo);
                gtu_pkg::DESC_AD:
                    word_out[0] = reg_write(hi[7:0], lo);
                default:    n = 0;   // nop and undefined descriptors
            endcase
        end else if (tag_state.mode == gtu_pkg::MODE_REGLIST) begin
            d = next_desc();
            step_desc();
            if (d != gtu_pkg::DESC_NOP) begin
                word_out[n] = reg_write({4'd0, d}, lo);
                n = n + 1;
            end
            // high half is padding once the loops run out
            if (tag_state.loops != 15'd0) begin
                d = next_desc();
                step_desc();
                if (d != gtu_pkg::DESC_NOP) begin
                    word_out[n] = reg_write({4'd0, d}, hi);
                    n = n + 1;
                end
            end
        end else begin
            word_out[0] = '{kind: gtu_pkg::KIND_IMAGE, addr: 8'd0, data_low: lo,
                            data_high: hi, last: 1'b0};
            n = 1;
            tag_state.loops = tag_state.loops - 15'd1;
        end
        if (n > 0)
            word_out[n - 1].last = 1'b1;
        return n;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic logic [63:0] tag_low(logic [3:0] nregs, logic [1:0] mode, logic prim,
                                            logic [9:0] prim_data, logic [14:0] loops);
        return {nregs, mode, 1'b0, prim_data, prim, 31'd0, loops};
    endfunction

    function automatic void plan_row(logic [63:0] lo, logic [63:0] hi);
        tag_row_t r;
        r.lo      = lo;
        r.hi      = hi;
        r.fixed   = 1'b0;
        r.n_fixed = 0;
        r.want    = '0;
        tag_plan  = {tag_plan, r};
    endfunction

    function automatic void plan_fixed(logic [63:0] lo, logic [63:0] hi, int n, logic kind,
                                       logic [7:0] addr, logic [63:0] dlo, logic [63:0] dhi);
        tag_row_t r;
        r.lo      = lo;
        r.hi      = hi;
        r.fixed   = 1'b1;
        r.n_fixed = n;
        r.want    = '{kind: kind, addr: addr, data_low: dlo, data_high: dhi, last: 1'b1};
        tag_plan  = {tag_plan, r};
    endfunction

    function automatic void load_plan();
        // all-zero tag: zero loops, next word is a tag again
        plan_fixed('0, '0, 0, gtu_pkg::KIND_REG, gtu_pkg::REG_PRIM, '0, '0);
        // packed, sixteen descriptors 0..f in order, one loop, prim write
        plan_fixed(tag_low(4'd0, gtu_pkg::MODE_PACKED, 1'b1, 10'h2AB, 15'd1),
                   64'hFEDC_BA98_7654_3210,
                   1, gtu_pkg::KIND_REG, gtu_pkg::REG_PRIM, 64'h2AB, '0);
        plan_row(64'h89AB_CDEF_0123_4567, 64'h0F1E_2D3C_4B5A_6978);
        // rgbaq with q still zero from reset
        plan_fixed('1, '1, 1, gtu_pkg::KIND_REG, gtu_pkg::REG_RGBAQ,
                   64'h0000_0000_FFFF_FFFF, '0);
        plan_fixed('1, '1, 1, gtu_pkg::KIND_REG, gtu_pkg::REG_ST, '1, '0);
        plan_row(64'h1234_8765_9ABC_F00D, 64'h5555_AAAA_3333_CCCC);
        plan_row(64'hDEAD_BEEF_CAFE_F00D, 64'h7FFF_1234_5678_9ABC);   // adc clear
        plan_row(64'h1357_9BDF_2468_ACE0, 64'h0000_8000_0123_4567);   // adc set
        plan_row(64'hA5A5_5A5A_0F0F_F0F0, 64'h0000_0000_0000_0001);
        plan_row(64'h0000_0000_0000_0001, '1);
        plan_row(64'h8000_0000_0000_0000, '0);
        // undefined descriptors 9..c give nothing
        plan_fixed('1, '1, 0, gtu_pkg::KIND_REG, gtu_pkg::REG_PRIM, '0, '0);
        plan_fixed('0, '0, 0, gtu_pkg::KIND_REG, gtu_pkg::REG_PRIM, '0, '0);
        plan_fixed(64'h0123_4567_89AB_CDEF, '1, 0, gtu_pkg::KIND_REG, gtu_pkg::REG_PRIM,
                   '0, '0);
        plan_fixed('1, '0, 0, gtu_pkg::KIND_REG, gtu_pkg::REG_PRIM, '0, '0);
        plan_row(64'h0F0F_0F0F_F0F0_F0F0, 64'h1111_2222_3333_4444);
        plan_row(64'h7766_5544_3322_1100, 64'hFFFF_FFFF_FFFF_FF3C);   // address plus data
        plan_fixed('1, '1, 0, gtu_pkg::KIND_REG, gtu_pkg::REG_PRIM, '0, '0);          // nop
        // reglist, three halves: second word ends on its low half, prim bit ignored
        plan_fixed(tag_low(4'd1, gtu_pkg::MODE_REGLIST, 1'b1, 10'h3FF, 15'd3), 64'h6,
                   0, gtu_pkg::KIND_REG, gtu_pkg::REG_PRIM, '0, '0);
        plan_row(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        plan_row(64'h1111_1111_2222_2222, 64'h3333_3333_4444_4444);
        // reglist with a nop first
        plan_fixed(tag_low(4'd2, gtu_pkg::MODE_REGLIST, 1'b0, 10'h0, 15'd1), 64'h2F,
                   0, gtu_pkg::KIND_REG, gtu_pkg::REG_PRIM, '0, '0);
        plan_row(64'h9999_8888_7777_6666, 64'h5555_4444_3333_2222);
        // image mode 3 with prim, two words
        plan_fixed(tag_low(4'd0, MODE_IMAGE_ALT, 1'b1, 10'h3FF, 15'd2), 64'h1234_5678_9ABC_DEF0,
                   1, gtu_pkg::KIND_REG, gtu_pkg::REG_PRIM, 64'h3FF, '0);
        plan_fixed('1, '1, 1, gtu_pkg::KIND_IMAGE, 8'd0, '1, '1);
        plan_fixed('0, '0, 1, gtu_pkg::KIND_IMAGE, 8'd0, '0, '0);
    endfunction

    function automatic tag_row_t random_tag();
        tag_row_t r;
        int       pick;
        r.fixed   = 1'b0;
        r.n_fixed = 0;
        r.want    = '0;
        r.lo      = {$urandom, $urandom};
        r.hi      = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        r.lo[14:0] = (pick < 8) ? 15'd0 : 15'($urandom_range(1, 3));
        pick = $urandom_range(0, 99);
        if (pick < 40)
            r.lo[59:58] = gtu_pkg::MODE_PACKED;
        else if (pick < 75)
            r.lo[59:58] = gtu_pkg::MODE_REGLIST;
        else if (pick < 90)
            r.lo[59:58] = MODE_IMAGE;
        else
            r.lo[59:58] = MODE_IMAGE_ALT;
        // short loops half the time
        if ($urandom_range(0, 1) == 0)
            r.lo[63:60] = 4'($urandom_range(1, 4));
        return r;
    endfunction

    function automatic tag_row_t random_data();
        tag_row_t r;
        int       pick;
        r.fixed   = 1'b0;
        r.n_fixed = 0;
        r.want    = '0;
        pick = $urandom_range(0, 31);
        if (pick == 0) begin
            r.lo = '1;
            r.hi = '1;
        end else if (pick == 1) begin
            r.lo = '0;
            r.hi = '0;
        end else begin
            r.lo = {$urandom, $urandom};
            r.hi = {$urandom, $urandom};
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- idling

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (light_idle)
            return 1;
        if (pick < 70)
            return $urandom_range(1, 2);
        if (pick < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 40);
    endfunction

    function automatic int sender_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if (tx_quiet > 0) begin
            tx_quiet--;
            return 0;
        end
        if ($urandom_range(0, 149) == 0) begin
            tx_quiet = $urandom_range(30, 120);
            return 0;
        end
        if ($urandom_range(0, 9) < 6)
            return 0;
        return idle_len();
    endfunction

    // offer one word, predict its results at the accepting edge
    task automatic send_word(input tag_row_t r);
        int gap;
        int n;
        int i;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r.hi, r.lo};
        do @(posedge aclk); while (!s_tready);
        n = unpack_word(r.lo, r.hi);
        if (r.fixed) begin
            if (r.n_fixed != 0)
                due_writes = {due_writes, r.want};
        end else begin
            for (i = 0; i < n; i++)
                due_writes = {due_writes, word_out[i]};
        end
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
            waited++;
        end while (due_writes.size() != 0 && waited < DRAIN_LIMIT);
    endtask

    // receiver: random stalls, quiet stretches, one long hold-off on request
    initial begin
        int stall_left;
        int rx_quiet;
        stall_left = 0;
        rx_quiet   = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (rx_quiet > 0)
                rx_quiet--;
            else if ($urandom_range(0, 199) == 0)
                rx_quiet = $urandom_range(40, 150);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (rx_quiet == 0 && $urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen = '{kind: m_tuser[0], addr: m_tdata[7:0], data_low: m_tdata[71:8],
                     data_high: m_tdata[135:72], last: m_tlast};
            if (due_writes.size() == 0) begin
                note_mismatch("result with nothing due, data_low", '0, seen.data_low);
            end else begin
                want = due_writes.pop_front();
                if (seen.kind !== want.kind)
                    note_mismatch("result_kind", 64'(want.kind), 64'(seen.kind));
                if (seen.addr !== want.addr)
                    note_mismatch("register_address", 64'(want.addr), 64'(seen.addr));
                if (seen.data_low !== want.data_low)
                    note_mismatch("data_low", want.data_low, seen.data_low);
                if (seen.data_high !== want.data_high)
                    note_mismatch("data_high", want.data_high, seen.data_high);
                if (seen.last !== want.last)
                    note_mismatch("last_result", 64'(want.last), 64'(seen.last));
            end
        end
    end

    // sender and end of run
    initial begin
        int       words;
        bit       hold_done;
        bit       pause_done;
        bit       was_tag;
        tag_row_t r;
        words      = 0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        tag_state  = '{loops: '0, mode: '0, nregs: '0, descs: '0, left: '0, q: '0};
        wait (aresetn == 1'b1);
        @(posedge aclk);

        load_plan();
        foreach (tag_plan[k])
            send_word(tag_plan[k]);
        wait_drained();

        // random tag sequences, always completed before the loop ends
        while (words < RANDOM_WORDS || tag_state.loops != 15'd0) begin
            if (!hold_done && words >= HOLD_AT) begin
                hold_done  = 1'b1;
                hold_req   = 1'b1;
                burst_left = 40;
            end
            if (!pause_done && words >= PAUSE_AT) begin
                pause_done = 1'b1;
                wait_drained();
            end
            was_tag = (tag_state.loops == 15'd0);
            r = was_tag ? random_tag() : random_data();
            send_word(r);
            if (!was_tag || r.lo[14:0] != 15'd0)
                words++;
        end

        // all-ones tag: widest loop count, only the first few image words of it
        light_idle = 1'b1;
        plan_fixed('1, '1, 1, gtu_pkg::KIND_REG, gtu_pkg::REG_PRIM, 64'h3FF, '0);
        send_word(tag_plan[$]);
        repeat (TAIL_WORDS)
            send_word(random_data());

        wait_drained();
        if (due_writes.size() != 0)
            note_mismatch("results never delivered, count", 64'(due_writes.size()), '0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

[graphics_tag_unpacker_core.f]
sv/gtu_pkg.sv
sv/gtu_unpack.sv
sv/gtu_out_queue.sv
sv/graphics_tag_unpacker_core.sv
sv/gtu_checker.sv
sim/graphics_tag_unpacker_core_tb.sv
